// File: hw/rtl/crq_pkg.sv
// ----------------------------------------------------------------------------
// crq_pkg
// Types, codes and defaults shared by the credit-ordered ready queue.
// ----------------------------------------------------------------------------
package crq_pkg;

  localparam int unsigned CapacityDefault = 16;

  typedef enum logic [1:0] {
    ModeInsert  = 2'd0,
    ModeLookup  = 2'd1,
    ModeRemove  = 2'd2,
    ModeRestore = 2'd3
  } crq_mode_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusFull     = 2'd1,
    StatusNotFound = 2'd2
  } crq_status_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] tid;
    logic [7:0] credits;
    logic [7:0] initial_credits;
  } crq_req_t;

  typedef struct packed {
    logic       found;
    logic [7:0] found_credits;
    logic       head_valid;
    logic [7:0] head_tid;
    logic [7:0] head_credits;
    logic [4:0] entry_count;
    logic [1:0] status;
  } crq_res_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic latch;
    logic compare;
    logic apply;
    logic respond;
  } crq_cmd_t;

endpackage

// File: hw/rtl/crq_ctrl.sv
// ----------------------------------------------------------------------------
// crq_ctrl
// Sequencer: takes a command, then steps it through compare, apply and
// respond.
// ----------------------------------------------------------------------------
module crq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output crq_pkg::crq_cmd_t cmd_o
);
  import crq_pkg::*;

  typedef enum logic [3:0] {
    StIdle    = 4'b0001,
    StCompare = 4'b0010,
    StApply   = 4'b0100,
    StRespond = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // A new command may be taken while the previous result is being strobed.
  assign busy_o = (state_q == StCompare) || (state_q == StApply);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:    if (accept) state_d = StCompare;
      StCompare: state_d = StApply;
      StApply:   state_d = StRespond;
      StRespond: state_d = accept ? StCompare : StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.latch   = accept;
  assign cmd_o.compare = (state_q == StCompare);
  assign cmd_o.apply   = (state_q == StApply);
  assign cmd_o.respond = (state_q == StRespond);

endmodule

// File: hw/rtl/crq_datapath.sv
// ----------------------------------------------------------------------------
// crq_datapath
// Row of queue cells with per-cell compare flags, insert/remove shifting,
// credit restore and the result register.
// ----------------------------------------------------------------------------
module crq_datapath #(
  parameter int unsigned CAPACITY = crq_pkg::CapacityDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  crq_pkg::crq_cmd_t cmd_i,
  input  crq_pkg::crq_req_t req_i,
  output crq_pkg::crq_res_t res_o
);
  import crq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CAPACITY-1:0] OneV = {{(CAPACITY-1){1'b0}}, 1'b1};

  crq_req_t            req_q;
  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [7:0]          tid_q [CAPACITY];
  logic [7:0]          cr_q  [CAPACITY];
  logic [7:0]          ic_q  [CAPACITY];
  logic [CAPACITY-1:0] lt_q, eq_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                found_q;
  logic [7:0]          fcred_q;
  logic [1:0]          status_q;

  logic                full;
  logic                do_insert, do_remove, do_restore;
  logic [CAPACITY-1:0] lt_first, slot_free, ins_oh, ins_ge;
  logic [CAPACITY-1:0] eq_first, rm_ge;
  logic                hit;
  logic [7:0]          fcred;
  logic [1:0]          status_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_i;
    end
  end

  // Compare step: every valid cell checks its credits and id at once.
  always_ff @(posedge clk_i) begin
    if (cmd_i.compare) begin
      for (int i = 0; i < CAPACITY; i++) begin
        lt_q[i] <= valid_q[i] && (cr_q[i] < req_q.credits);
        eq_q[i] <= valid_q[i] && (tid_q[i] == req_q.tid);
      end
    end
  end

  assign full      = valid_q[CAPACITY-1];
  assign hit       = |eq_q;
  // Lowest set flag wins; credits may be out of order after a restore.
  assign lt_first  = lt_q & (~lt_q + OneV);
  assign slot_free = ~valid_q & {valid_q[CAPACITY-2:0], 1'b1};
  assign ins_oh    = (|lt_q) ? lt_first : slot_free;
  assign ins_ge    = ~(ins_oh - OneV);
  assign eq_first  = eq_q & (~eq_q + OneV);
  assign rm_ge     = ~(eq_first - OneV);

  assign do_insert  = cmd_i.apply && (req_q.mode == ModeInsert) && !full;
  assign do_remove  = cmd_i.apply && (req_q.mode == ModeRemove) && hit;
  assign do_restore = cmd_i.apply && (req_q.mode == ModeRestore);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (do_insert && ins_oh[g]) begin
        tid_q[g] <= req_q.tid;
        cr_q[g]  <= req_q.credits;
        ic_q[g]  <= req_q.initial_credits;
      end else if (do_insert && ins_ge[g]) begin
        if (g > 0) begin
          tid_q[g] <= tid_q[(g > 0) ? g - 1 : 0];
          cr_q[g]  <= cr_q[(g > 0) ? g - 1 : 0];
          ic_q[g]  <= ic_q[(g > 0) ? g - 1 : 0];
        end
      end else if (do_remove && rm_ge[g]) begin
        if (g < CAPACITY - 1) begin
          tid_q[g] <= tid_q[(g < CAPACITY - 1) ? g + 1 : g];
          cr_q[g]  <= cr_q[(g < CAPACITY - 1) ? g + 1 : g];
          ic_q[g]  <= ic_q[(g < CAPACITY - 1) ? g + 1 : g];
        end
      end else if (do_restore) begin
        cr_q[g] <= ic_q[g];
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    if (do_insert) begin
      valid_d = {valid_q[CAPACITY-2:0], 1'b1};
      cnt_d   = cnt_q + CntW'(1);
    end else if (do_remove) begin
      valid_d = valid_q >> 1;
      cnt_d   = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    fcred = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      fcred = fcred | (eq_first[i] ? cr_q[i] : 8'd0);
    end
    case (req_q.mode)
      ModeInsert:             status_d = full ? StatusFull : StatusOk;
      ModeLookup, ModeRemove: status_d = hit ? StatusOk : StatusNotFound;
      default:                status_d = StatusOk;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      found_q  <= ((req_q.mode == ModeLookup) || (req_q.mode == ModeRemove)) && hit;
      fcred_q  <= ((req_q.mode == ModeLookup) || (req_q.mode == ModeRemove)) ? fcred : 8'd0;
      status_q <= status_d;
    end
  end

  assign res_o.found         = found_q;
  assign res_o.found_credits = fcred_q;
  assign res_o.head_valid    = valid_q[0];
  assign res_o.head_tid      = valid_q[0] ? tid_q[0] : 8'd0;
  assign res_o.head_credits  = valid_q[0] ? cr_q[0] : 8'd0;
  assign res_o.entry_count   = 5'(cnt_q);
  assign res_o.status        = status_q;

  a_count_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) == $countones(valid_q))
    else $error("entry count disagrees with valid bits");

  a_valid_packed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q & ~{valid_q[CAPACITY-2:0], 1'b1}) == '0)
    else $error("valid slots are not a run from the head");

  a_full_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && (req_q.mode == ModeInsert) && full) |=> $stable(valid_q))
    else $error("insert into a full queue changed the occupancy");

endmodule

// File: hw/rtl/credit_ordered_ready_queue_unit.sv
// ----------------------------------------------------------------------------
// credit_ordered_ready_queue_unit
// Credit-ordered ready queue: a row of cells kept in descending credit order until a restore.
// ----------------------------------------------------------------------------
// A taken command passes through the compare, apply and respond steps of the
// sequencer in that order, and its result is strobed on done_o in the respond
// step. A new command is taken while the previous result is being strobed,
// but not during compare or apply. The receiver cannot stall results.
// Reset clears the valid bits and the sequencer at once; no clearing pass.
module credit_ordered_ready_queue_unit #(
  parameter int unsigned CAPACITY = crq_pkg::CapacityDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  crq_pkg::crq_req_t req_i,
  output logic              done_o,
  output crq_pkg::crq_res_t res_o
);
  import crq_pkg::*;

  crq_cmd_t cmd;

  crq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  crq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .res_o  (res_o)
  );

  assign done_o = cmd.respond;

endmodule
